// ----- hw/rtl/bcid_pkg.sv -----
`default_nettype none

package bcid_pkg;

    // Operation codes, numbered in table order of first appearance
    localparam logic [4:0] OP_NOP     = 5'd0;
    localparam logic [4:0] OP_RET     = 5'd1;
    localparam logic [4:0] OP_NOT     = 5'd2;
    localparam logic [4:0] OP_NEG     = 5'd3;
    localparam logic [4:0] OP_ADD     = 5'd4;
    localparam logic [4:0] OP_SUB     = 5'd5;
    localparam logic [4:0] OP_MUL     = 5'd6;
    localparam logic [4:0] OP_MULU    = 5'd7;
    localparam logic [4:0] OP_DIV     = 5'd8;
    localparam logic [4:0] OP_DIVU    = 5'd9;
    localparam logic [4:0] OP_MOD     = 5'd10;
    localparam logic [4:0] OP_MODU    = 5'd11;
    localparam logic [4:0] OP_AND     = 5'd12;
    localparam logic [4:0] OP_OR      = 5'd13;
    localparam logic [4:0] OP_XOR     = 5'd14;
    localparam logic [4:0] OP_SHL     = 5'd15;
    localparam logic [4:0] OP_SHR     = 5'd16;
    localparam logic [4:0] OP_MOVBW   = 5'd17;
    localparam logic [4:0] OP_MOVWW   = 5'd18;
    localparam logic [4:0] OP_MOVDW   = 5'd19;
    localparam logic [4:0] OP_MOVQW   = 5'd20;
    localparam logic [4:0] OP_MOVBD   = 5'd21;
    localparam logic [4:0] OP_MOVWD   = 5'd22;
    localparam logic [4:0] OP_MOVDD   = 5'd23;
    localparam logic [4:0] OP_MOVQD   = 5'd24;
    localparam logic [4:0] OP_MOVQQ   = 5'd25;
    localparam logic [4:0] OP_STORESP = 5'd26;
    localparam logic [4:0] OP_PUSH    = 5'd27;
    localparam logic [4:0] OP_POP     = 5'd28;
    localparam logic [4:0] OP_PUSHN   = 5'd29;
    localparam logic [4:0] OP_POPN    = 5'd30;

    // Highest dedicated register number accepted by STORESP
    localparam logic [2:0] MAX_DEDICATED_REG = 3'd2;

    typedef struct packed {
        logic [7:0]  opcode_byte;
        logic [7:0]  operand_byte;
        logic [63:0] ext_low;
        logic [63:0] ext_high;
    } t_bcid_in;

    typedef struct packed {
        logic [4:0]  operation;
        logic        flag_seven;
        logic        flag_six;
        logic        first_indirect;
        logic [2:0]  first_register;
        logic        second_indirect;
        logic [2:0]  second_register;
        logic [3:0]  move_width;
        logic [3:0]  index_width;
        logic [63:0] first_value;
        logic [63:0] second_index;
        logic        decode_error;
    } t_bcid_out;

    // Opcode table: low six opcode bits to operation, unassigned give NOP
    function automatic logic [4:0] op_lookup(input logic [5:0] code);
        logic [4:0] op;
        op = OP_NOP;
        case (code)
            6'h04: op = OP_RET;
            6'h0a: op = OP_NOT;
            6'h0b: op = OP_NEG;
            6'h0c: op = OP_ADD;
            6'h0d: op = OP_SUB;
            6'h0e: op = OP_MUL;
            6'h0f: op = OP_MULU;
            6'h10: op = OP_DIV;
            6'h11: op = OP_DIVU;
            6'h12: op = OP_MOD;
            6'h13: op = OP_MODU;
            6'h14: op = OP_AND;
            6'h15: op = OP_OR;
            6'h16: op = OP_XOR;
            6'h17: op = OP_SHL;
            6'h18: op = OP_SHR;
            6'h1d: op = OP_MOVBW;
            6'h1e: op = OP_MOVWW;
            6'h1f: op = OP_MOVDW;
            6'h20: op = OP_MOVQW;
            6'h21: op = OP_MOVBD;
            6'h22: op = OP_MOVWD;
            6'h23: op = OP_MOVDD;
            6'h24: op = OP_MOVQD;
            6'h28: op = OP_MOVQQ;
            6'h2a: op = OP_STORESP;
            6'h2b: op = OP_PUSH;
            6'h2c: op = OP_POP;
            6'h35: op = OP_PUSHN;
            6'h36: op = OP_POPN;
            default: op = OP_NOP;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/byte_code_instruction_decoder.sv -----
`default_nettype none

// Channel   Direction  Handshake           Payload
// request   in         i_valid / o_ready   i_data (bcid_pkg::t_bcid_in)
// result    out        o_valid / i_ready   o_data (bcid_pkg::t_bcid_out)
//
// One request per cycle while either stage has room; an accepted request
// passes the input register, table decode and result register.
// Synchronous active-low reset clears both stage valid bits only.
// A stalled result holds in the result register; the input stage keeps
// taking requests while either stage has room.

module byte_code_instruction_decoder (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire bcid_pkg::t_bcid_in  i_data,
    output logic                     o_valid,
    input  wire                      i_ready,
    output bcid_pkg::t_bcid_out      o_data
);

    logic                 r_in_valid;
    bcid_pkg::t_bcid_in   r_in;
    logic                 r_out_valid;
    bcid_pkg::t_bcid_out  r_out;
    bcid_pkg::t_bcid_out  n_out;
    logic                 out_room;

    // Stage handshakes
    assign out_room = !r_out_valid || i_ready;
    assign o_ready  = !r_in_valid || out_room;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
    end

    bcid_decode u_decode (
        .i_instr (r_in),
        .o_dec   (n_out)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_room) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_room && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ----- hw/rtl/bcid_decode.sv -----
`default_nettype none

module bcid_decode (
    input  wire bcid_pkg::t_bcid_in  i_instr,
    output bcid_pkg::t_bcid_out      o_dec
);

    logic [4:0]  op;
    logic        f7;
    logic        f6;
    logic [2:0]  r2;
    logic [3:0]  mw;
    logic [3:0]  iw;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] lo;
    logic [63:0] hi;

    assign op = bcid_pkg::op_lookup(i_instr.opcode_byte[5:0]);
    assign f7 = i_instr.opcode_byte[7];
    assign f6 = i_instr.opcode_byte[6];
    assign r2 = i_instr.operand_byte[6:4];
    assign lo = i_instr.ext_low;
    assign hi = i_instr.ext_high;

    // Move kind gives data width and index width; indexes follow each other
    always_comb begin
        mw = 4'd0;
        iw = 4'd0;
        v1 = '0;
        v2 = '0;
        case (op)
            bcid_pkg::OP_MOVBW, bcid_pkg::OP_MOVWW,
            bcid_pkg::OP_MOVDW, bcid_pkg::OP_MOVQW: begin
                iw = 4'd2;
                mw = 4'd1 << (op - bcid_pkg::OP_MOVBW);
                if (f7) v1 = {48'd0, lo[15:0]};
                if (f6) v2 = f7 ? {48'd0, lo[31:16]} : {48'd0, lo[15:0]};
            end
            bcid_pkg::OP_MOVBD, bcid_pkg::OP_MOVWD,
            bcid_pkg::OP_MOVDD, bcid_pkg::OP_MOVQD: begin
                iw = 4'd4;
                mw = 4'd1 << (op - bcid_pkg::OP_MOVBD);
                if (f7) v1 = {32'd0, lo[31:0]};
                if (f6) v2 = f7 ? {32'd0, lo[63:32]} : {32'd0, lo[31:0]};
            end
            bcid_pkg::OP_MOVQQ: begin
                iw = 4'd8;
                mw = 4'd8;
                if (f7) v1 = lo;
                if (f6) v2 = f7 ? hi : lo;
            end
            default: begin
                // immediate is the first two extension bytes
                if (f7) v1 = {48'd0, lo[15:0]};
            end
        endcase
    end

    // Field assembly
    always_comb begin
        o_dec.operation       = op;
        o_dec.flag_seven      = f7;
        o_dec.flag_six        = f6;
        o_dec.first_indirect  = i_instr.operand_byte[3];
        o_dec.first_register  = i_instr.operand_byte[2:0];
        o_dec.second_indirect = i_instr.operand_byte[7];
        o_dec.second_register = r2;
        o_dec.move_width      = mw;
        o_dec.index_width     = iw;
        o_dec.first_value     = v1;
        o_dec.second_index    = v2;
        o_dec.decode_error    = (op == bcid_pkg::OP_STORESP) &&
                                (r2 > bcid_pkg::MAX_DEDICATED_REG);
    end

endmodule

`default_nettype wire
